// ===== src/tddf_pkg.sv =====
// ----------------------------------------------------------------------------
// tddf_pkg
// Shared types and constants for the touch dejitter / delta filter.
// ----------------------------------------------------------------------------
package tddf_pkg;

  localparam int MAX_HISTORY = 16;
  localparam int COORD_BITS  = 16;
  localparam int AXES        = 2;

  localparam int SLOT_W      = $clog2(MAX_HISTORY);
  localparam int LEN_W       = $clog2(MAX_HISTORY + 1);
  localparam int NDIV_W      = LEN_W + 1;
  localparam int HLEN_CFG_W  = 5;
  localparam int MARGIN_W    = 8;
  localparam int ACC_W       = COORD_BITS + SLOT_W + 2;
  localparam int MAG_W       = ACC_W - 1;
  localparam int DCNT_W      = $clog2(MAG_W + 1);
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic [HLEN_CFG_W-1:0] HIST_RESET_LEN = HLEN_CFG_W'(4);
  localparam logic [MARGIN_W-1:0]   MARGIN_RESET   = MARGIN_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_MARGIN  = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sample_x;
    logic signed [COORD_BITS-1:0] sample_y;
    logic                         new_touch;
  } sample_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] filtered_x;
    logic signed [COORD_BITS-1:0] filtered_y;
    logic signed [COORD_BITS-1:0] delta_x;
    logic signed [COORD_BITS-1:0] delta_y;
    logic                         delta_ready;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_LAST,
    S_DEJIT,
    S_ACC,
    S_DRAIN,
    S_DIVINIT,
    S_DIV,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic norm_step;
    logic rd_last;
    logic dejitter;
    logic acc_step;
    logic div_init;
    logic div_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic ws_ge_len;
    logic has_hist;
    logic full;
    logic acc_last;
    logic div_last;
  } status_t;

endpackage

// ===== src/touch_dejitter_delta_filter.sv =====
// ----------------------------------------------------------------------------
// touch_dejitter_delta_filter
// Hysteresis dejitter and history-averaged motion delta for touch samples.
//
//   channel  direction  handshake                   payload
//   sample   in         sample_valid / sample_stall sample_t
//   result   out        result_valid / result_stall result_t
//   cfg      in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One sample is processed at a time. With a full history it makes n - 1 ring
// reads (n is L rounded up to even), a drain state and a 21-step restoring
// divide. With no stored point it goes straight to the push; with a partial
// history it first dejitters against the last point. A length change first
// normalizes the write slot. Reset is synchronous and clears the sequencer,
// registers, write slot and fill count; ring contents are undefined until
// written. A stalled result holds; the next sample is taken meanwhile and
// waits at the push until the result drains.
// ----------------------------------------------------------------------------
module touch_dejitter_delta_filter
  import tddf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tddf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  tddf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while previous transaction still in progress");

  a_no_delta_unless_ready: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.delta_ready |-> result.delta_x == '0 && result.delta_y == '0)
    else $error("nonzero delta without full history");

  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !result_valid || !result_stall)
    else $error("result overwritten while stalled");

endmodule

// ===== src/tddf_ram.sv =====
// ----------------------------------------------------------------------------
// tddf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tddf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/tddf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tddf_ctrl
// Sequencer: normalize slot, dejitter, walk history, divide, push.
// ----------------------------------------------------------------------------
module tddf_ctrl
  import tddf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  output logic    result_valid,
  input  logic    result_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) state_next = S_NORM;
      end
      S_NORM: begin
        if (!status.ws_ge_len) begin
          state_next = status.has_hist ? S_LAST : S_PUSH;
        end
      end
      S_LAST:    state_next = S_DEJIT;
      S_DEJIT:   state_next = status.full ? S_ACC : S_PUSH;
      S_ACC: begin
        if (status.acc_last) state_next = S_DRAIN;
      end
      S_DRAIN:   state_next = S_DIVINIT;
      S_DIVINIT: state_next = S_DIV;
      S_DIV: begin
        if (status.div_last) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    sample_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        cmd.load     = sample_valid;
      end
      S_NORM:    cmd.norm_step = status.ws_ge_len;
      S_LAST:    cmd.rd_last   = 1'b1;
      S_DEJIT:   cmd.dejitter  = 1'b1;
      S_ACC:     cmd.acc_step  = 1'b1;
      S_DRAIN:   cmd           = '0;
      S_DIVINIT: cmd.div_init  = 1'b1;
      S_DIV:     cmd.div_step  = 1'b1;
      S_PUSH:    cmd.push      = out_free;
      default:   cmd           = '0;
    endcase
  end

endmodule

// ===== src/tddf_dp.sv =====
// ----------------------------------------------------------------------------
// tddf_dp
// Datapath: config registers, history ring, dead band, accumulator, divider.
// ----------------------------------------------------------------------------
module tddf_dp
  import tddf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  sample_t               sample,
  input  cmd_t                  cmd,
  output status_t               status,
  output result_t               result
);

  localparam int CW = COORD_BITS;

  function automatic logic signed [CW-1:0] dead_band(
    input logic signed [CW-1:0] s,
    input logic signed [CW-1:0] c,
    input logic [MARGIN_W-1:0]  m
  );
    logic signed [CW+1:0] se;
    logic signed [CW+1:0] ce;
    logic signed [CW+1:0] d;
    logic signed [CW+1:0] mm;
    logic signed [CW+1:0] r;
    se = (CW+2)'(s);
    ce = (CW+2)'(c);
    mm = $signed({{(CW+2-MARGIN_W){1'b0}}, m});
    d  = se - ce;
    if (d > mm) begin
      r = se - mm;
    end else if (d < -mm) begin
      r = se + mm;
    end else begin
      r = ce;
    end
    return r[CW-1:0];
  endfunction

  logic [HLEN_CFG_W-1:0] hist_len;
  logic [MARGIN_W-1:0]   margin;
  logic [LEN_W-1:0]      len_eff;

  logic [LEN_W-1:0]      len;
  logic [NDIV_W-1:0]     n;
  logic [SLOT_W-1:0]     ws;
  logic [LEN_W-1:0]      fc;
  logic [SLOT_W-1:0]     ptr;
  logic [LEN_W-1:0]      idx;
  logic                  pend;
  logic                  pend_add;
  logic [DCNT_W-1:0]     dcnt;

  logic signed [CW-1:0]    raw   [AXES];
  logic signed [CW-1:0]    filt  [AXES];
  logic signed [ACC_W-1:0] acc   [AXES];
  logic [MAG_W-1:0]        quo   [AXES];
  logic [NDIV_W-1:0]       rem   [AXES];
  logic                    neg   [AXES];
  logic signed [CW-1:0]    rd_pt [AXES];
  logic signed [CW-1:0]    db    [AXES];
  logic signed [CW-1:0]    dq    [AXES];
  logic [NDIV_W:0]         rsh   [AXES];
  logic [MAG_W-1:0]        q_mag [AXES];

  logic [SLOT_W-1:0]     last_slot;
  logic [SLOT_W-1:0]     ptr_dec;
  logic [SLOT_W-1:0]     len_m1;
  logic [LEN_W-1:0]      ws_inc;
  logic [NDIV_W-1:0]     half;
  logic [2*CW-1:0]       ram_q;
  logic [SLOT_W-1:0]     rd_addr;

  // effective history length, clamped to 1..MAX_HISTORY
  always_comb begin
    if (hist_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(hist_len) > MAX_HISTORY) begin
      len_eff = LEN_W'(MAX_HISTORY);
    end else begin
      len_eff = LEN_W'(hist_len);
    end
  end

  assign len_m1    = SLOT_W'(len - LEN_W'(1));
  assign last_slot = (ws == '0) ? len_m1 : ws - SLOT_W'(1);
  assign ptr_dec   = (ptr == '0) ? len_m1 : ptr - SLOT_W'(1);
  assign ws_inc    = LEN_W'(ws) + LEN_W'(1);
  assign half      = n >> 1;
  assign rd_addr   = cmd.rd_last ? last_slot : ptr;

  assign rd_pt[0] = ram_q[2*CW-1:CW];
  assign rd_pt[1] = ram_q[CW-1:0];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      db[a]    = dead_band(raw[a], rd_pt[a], margin);
      rsh[a]   = {rem[a], quo[a][MAG_W-1]};
      q_mag[a] = neg[a] ? (~quo[a] + MAG_W'(1)) : quo[a];
      dq[a]    = q_mag[a][CW-1:0];
    end
  end

  assign status.ws_ge_len = LEN_W'(ws) >= len;
  assign status.has_hist  = fc != '0;
  assign status.full      = fc >= len;
  assign status.acc_last  = NDIV_W'(idx) == n - NDIV_W'(1);
  assign status.div_last  = dcnt == DCNT_W'(1);

  tddf_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_HISTORY)
  ) u_hist (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (ws),
    .wr_data ({filt[0], filt[1]}),
    .rd_en   (cmd.rd_last || cmd.acc_step),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // config and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len <= HIST_RESET_LEN;
      margin   <= MARGIN_RESET;
      ws       <= '0;
      fc       <= '0;
      pend     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_HISTORY_LENGTH: hist_len <= cfg_data[HLEN_CFG_W-1:0];
          REG_JITTER_MARGIN:  margin   <= cfg_data[MARGIN_W-1:0];
          default: ;
        endcase
      end
      pend <= cmd.acc_step;
      if (cmd.load) begin
        if (sample.new_touch) begin
          ws <= '0;
          fc <= '0;
        end else if (fc > len_eff) begin
          fc <= len_eff;
        end
      end else if (cmd.norm_step) begin
        ws <= SLOT_W'(LEN_W'(ws) - len);
      end else if (cmd.push) begin
        ws <= (ws_inc == len) ? '0 : ws_inc[SLOT_W-1:0];
        if (fc < len) fc <= fc + LEN_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len    <= len_eff;
      n      <= NDIV_W'(len_eff) + NDIV_W'(len_eff[0]);
      raw[0] <= sample.sample_x;
      raw[1] <= sample.sample_y;
      filt[0] <= sample.sample_x;
      filt[1] <= sample.sample_y;
    end
    if (cmd.rd_last) begin
      ptr <= last_slot;
    end
    if (cmd.acc_step) begin
      ptr      <= ptr_dec;
      idx      <= idx + LEN_W'(1);
      pend_add <= NDIV_W'(idx) < half;
    end
    if (cmd.dejitter) begin
      idx <= LEN_W'(1);
    end
    if (cmd.div_init) begin
      dcnt <= DCNT_W'(MAG_W);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - DCNT_W'(1);
    end
    for (int a = 0; a < AXES; a++) begin
      if (cmd.dejitter) begin
        filt[a] <= db[a];
        acc[a]  <= ACC_W'(db[a]);
      end else if (pend) begin
        acc[a] <= pend_add ? acc[a] + ACC_W'(rd_pt[a]) : acc[a] - ACC_W'(rd_pt[a]);
      end
      if (cmd.div_init) begin
        neg[a] <= acc[a][ACC_W-1];
        quo[a] <= acc[a][ACC_W-1] ? MAG_W'(-acc[a]) : MAG_W'(acc[a]);
        rem[a] <= '0;
      end else if (cmd.div_step) begin
        if (rsh[a] >= {1'b0, n}) begin
          rem[a] <= NDIV_W'(rsh[a] - {1'b0, n});
          quo[a] <= {quo[a][MAG_W-2:0], 1'b1};
        end else begin
          rem[a] <= rsh[a][NDIV_W-1:0];
          quo[a] <= {quo[a][MAG_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.push) begin
      result.filtered_x  <= filt[0];
      result.filtered_y  <= filt[1];
      result.delta_x     <= status.full ? dq[0] : '0;
      result.delta_y     <= status.full ? dq[1] : '0;
      result.delta_ready <= status.full;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the touch dejitter / delta filter. A scoreboard
// class predicts each result from the accepted samples and the current
// register values. The bench runs a directed sequence first, then random
// touches across a series of ring lengths and dead bands. Both sides idle
// and stall at random, with one phase run back to back.
// ----------------------------------------------------------------------------
module tb
  import tddf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   ITEMS_PER_PHASE = 128;
  localparam int                   CYCLE_LIMIT     = 400000;
  localparam int                   TAIL_CYCLES     = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED    = CFG_IDX_W'(15);

  class touch_filter_scoreboard;
    longint         hist_x [MAX_HISTORY];
    longint         hist_y [MAX_HISTORY];
    bit             written[MAX_HISTORY];
    int unsigned    slot;
    int unsigned    count;
    logic [4:0]     hist_len;
    logic [7:0]     margin;
    result_t        due_results[$];
    int             errors;
    int             checked;
    int             accepted;
    int             touches;

    function new();
      foreach (written[i]) written[i] = 1'b0;
      slot     = 0;
      count    = 0;
      hist_len = HIST_RESET_LEN;
      margin   = MARGIN_RESET;
      errors   = 0;
      checked  = 0;
      accepted = 0;
      touches  = 0;
    endfunction

    function int unsigned ring_len();
      int unsigned l;
      l = hist_len;
      if (l < 1) l = 1;
      if (l > MAX_HISTORY) l = MAX_HISTORY;
      return l;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_HISTORY_LENGTH: hist_len = val[4:0];
        REG_JITTER_MARGIN:  margin   = val;
        default: ;
      endcase
    endfunction

    // Ring position and fill level as the block sees them for the next sample.
    function void settle(input bit start, output int unsigned s, output int unsigned c);
      int unsigned len;
      len = ring_len();
      s = start ? 0 : slot;
      c = start ? 0 : count;
      if (c > len) c = len;
      s = s % len;
    endfunction

    // True if the next sample would touch a ring entry never written since reset.
    function bit reads_unwritten(bit start);
      int unsigned len, s, c, n;
      bit          hit;
      len = ring_len();
      settle(start, s, c);
      n   = ((len + 1) / 2) * 2;
      hit = 1'b0;
      if (c > 0 && !written[(s + len - 1) % len]) hit = 1'b1;
      if (c >= len)
        for (int unsigned i = 1; i < n; i++)
          if (!written[(s + len - i) % len]) hit = 1'b1;
      return hit;
    endfunction

    function longint dejitter(longint v, longint center, longint m);
      longint d;
      d = v - center;
      if (d > m) d -= m;
      else if (d < -m) d += m;
      else d = 0;
      return center + d;
    endfunction

    function void note_sample(sample_t smp);
      int unsigned len, n, last, idx;
      longint      x, y, dx, dy;
      result_t     r;
      len = ring_len();
      settle(smp.new_touch, slot, count);
      x  = $signed(smp.sample_x);
      y  = $signed(smp.sample_y);
      dx = 0;
      dy = 0;
      r.delta_ready = 1'b0;
      if (count > 0) begin
        last = (slot + len - 1) % len;
        x = dejitter(x, hist_x[last], longint'(margin));
        y = dejitter(y, hist_y[last], longint'(margin));
      end
      if (count >= len) begin
        n  = ((len + 1) / 2) * 2;
        dx = x;
        dy = y;
        for (int unsigned i = 1; i < n; i++) begin
          idx = (slot + len - i) % len;
          if (i + 1 <= n / 2) begin
            dx += hist_x[idx];
            dy += hist_y[idx];
          end else begin
            dx -= hist_x[idx];
            dy -= hist_y[idx];
          end
        end
        dx = dx / longint'(n);
        dy = dy / longint'(n);
        r.delta_ready = 1'b1;
      end
      hist_x[slot]  = x;
      hist_y[slot]  = y;
      written[slot] = 1'b1;
      if (count < len) count++;
      slot = (slot + 1) % len;
      r.filtered_x = x[15:0];
      r.filtered_y = y[15:0];
      r.delta_x    = dx[15:0];
      r.delta_y    = dy[15:0];
      due_results.push_back(r);
      accepted++;
      if (smp.new_touch) touches++;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("result transaction with no sample outstanding");
        return;
      end
      want = due_results.pop_front();
      if (got.filtered_x !== want.filtered_x)
        report($sformatf("result %0d filtered_x %0d, expected %0d",
                         checked, got.filtered_x, want.filtered_x));
      if (got.filtered_y !== want.filtered_y)
        report($sformatf("result %0d filtered_y %0d, expected %0d",
                         checked, got.filtered_y, want.filtered_y));
      if (got.delta_x !== want.delta_x)
        report($sformatf("result %0d delta_x %0d, expected %0d",
                         checked, got.delta_x, want.delta_x));
      if (got.delta_y !== want.delta_y)
        report($sformatf("result %0d delta_y %0d, expected %0d",
                         checked, got.delta_y, want.delta_y));
      if (got.delta_ready !== want.delta_ready)
        report($sformatf("result %0d delta_ready %b, expected %b",
                         checked, got.delta_ready, want.delta_ready));
      checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample       = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  touch_filter_scoreboard sb = new();
  bit steady      = 1'b0;
  int cycle_count = 0;
  int reg_writes  = 0;
  int phases      = 1;
  int pos_x       = 0;
  int pos_y       = 0;

  touch_dejitter_delta_filter DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    result_stall <= !rst && !steady && ($urandom_range(99) < 26);
  end

  task automatic send_sample(input bit start, input int x, input int y);
    sample_t s;
    s.new_touch = start || sb.reads_unwritten(start);
    s.sample_x  = x[15:0];
    s.sample_y  = y[15:0];
    pos_x = x;
    pos_y = y;
    while (!steady && $urandom_range(99) < 26) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    reg_writes++;
  endtask

  task automatic wait_results();
    sample_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  function automatic int walk(int p, int unsigned m);
    int step;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: step = int'($urandom_range(2 * m + 2)) - int'(m) - 1;
      5, 6, 7:       step = int'($urandom_range(200)) - 100;
      8:             step = int'($urandom_range(4000)) - 2000;
      default:       step = int'($urandom_range(65535)) - 32768;
    endcase
    p += step;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p;
  endfunction

  function automatic int start_point();
    case ($urandom_range(5))
      0:       return -32768 + int'($urandom_range(40));
      1:       return 32767 - int'($urandom_range(40));
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic random_items(input int total);
    int sent;
    int span;
    int x, y;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(99) < 85) begin
        span = $urandom_range(1, 3 * sb.ring_len() + 6);
        x = start_point();
        y = start_point();
        for (int k = 0; k < span && sent < total; k++) begin
          if (k != 0) begin
            x = walk(x, sb.margin);
            y = walk(y, sb.margin);
          end
          send_sample(k == 0, x, y);
          sent++;
        end
      end else begin
        send_sample($urandom_range(3) == 0, int'($urandom_range(65535)) - 32768,
                    int'($urandom_range(65535)) - 32768);
        sent++;
      end
    end
  endtask

  // Settle, reprogram, carry the current touch across the change, then randomize.
  task automatic run_phase(input logic [7:0] len_val, input logic [7:0] margin_val,
                           input bit no_idle, input bit poke_unmapped);
    wait_results();
    if (poke_unmapped) write_reg(REG_UNMAPPED, 8'hFF);
    write_reg(REG_HISTORY_LENGTH, len_val);
    write_reg(REG_JITTER_MARGIN, margin_val);
    cfg_valid <= 1'b0;
    steady = no_idle;
    phases++;
    for (int k = 0; k < 3; k++) send_sample(1'b0, walk(pos_x, sb.margin), walk(pos_y, sb.margin));
    random_items(ITEMS_PER_PHASE);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: ring of 4, dead band of 8
    send_sample(1'b0, 0, 0);
    send_sample(1'b0, 5, -5);
    send_sample(1'b0, 8, -8);
    send_sample(1'b0, 17, -17);
    send_sample(1'b0, 32767, -32768);
    send_sample(1'b0, 32767, -32768);
    send_sample(1'b0, -32768, 32767);
    send_sample(1'b0, -32768, 32767);
    send_sample(1'b0, -32768, 32767);
    send_sample(1'b0, 32767, -32768);
    send_sample(1'b0, 32767, -32768);
    send_sample(1'b1, -1, -1);
    send_sample(1'b1, 32767, 32767);
    send_sample(1'b0, 32766, 32760);
    send_sample(1'b0, -32768, -32768);
    send_sample(1'b0, 100, -100);
    send_sample(1'b0, 91, -91);
    send_sample(1'b0, 0, 0);
    send_sample(1'b0, -9, 9);
    random_items(ITEMS_PER_PHASE);

    run_phase(8'd1,   8'd0,   1'b0, 1'b0);
    run_phase(8'd16,  8'd255, 1'b0, 1'b0);
    run_phase(8'hE5,  8'd3,   1'b0, 1'b0);
    run_phase(8'd2,   8'd1,   1'b0, 1'b1);
    run_phase(8'd0,   8'd20,  1'b1, 1'b0);
    run_phase(8'd31,  8'd0,   1'b0, 1'b0);
    run_phase(8'd7,   8'd64,  1'b0, 1'b0);
    run_phase(8'd3,   8'd170, 1'b0, 1'b0);
    run_phase(8'd12,  8'd85,  1'b0, 1'b0);
    run_phase(8'($urandom_range(1, 16)), 8'($urandom_range(255)), 1'b0, 1'b0);

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d samples in %0d touches over %0d register settings",
             sb.accepted, sb.touches, phases);
    $display("%0d results compared, %0d register writes, %0d mismatches",
             sb.checked, reg_writes, sb.errors);
    if (sb.errors == 0 && sb.due_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
